// ===== rtl/tlos_pkg.sv =====
// Shared types, constants and the microcode program of the tile line-of-sight block.
package tlos_pkg;

    // Default map size and line step limit
    localparam int MAP_WIDTH_DEF  = 32;
    localparam int MAP_HEIGHT_DEF = 32;
    localparam int LINE_LIMIT_DEF = 128;

    // Fixed field widths
    localparam int COORD_W    = 5;
    localparam int FLAGS_W    = 8;
    localparam int FRAC_BITS  = 8;
    localparam int MAG_W      = COORD_W + FRAC_BITS;   // 5.8 magnitude of a delta
    localparam int POS_W      = 16;                    // signed 8.8 position
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Command codes carried in tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes
    localparam logic REG_SOLID       = 1'b0;
    localparam logic REG_TRANSPARENT = 1'b1;

    localparam logic [FLAGS_W-1:0] SOLID_RESET       = 8'h01;
    localparam logic [FLAGS_W-1:0] TRANSPARENT_RESET = 8'h02;

    // Microcode program counter
    typedef logic [2:0] t_pc;
    localparam t_pc PC_IDLE  = 3'd0;
    localparam t_pc PC_NORM  = 3'd1;
    localparam t_pc PC_START = 3'd2;
    localparam t_pc PC_READ  = 3'd3;
    localparam t_pc PC_CHECK = 3'd4;
    localparam t_pc PC_EMIT  = 3'd5;

    // Branch conditions
    typedef logic [2:0] t_cond;
    localparam t_cond COND_ALWAYS   = 3'd0;
    localparam t_cond COND_QUERY_IN = 3'd1;  // a query item accepted
    localparam t_cond COND_NORM_END = 3'd2;  // integer parts zero or limit hit
    localparam t_cond COND_FAIL     = 3'd3;  // line too long
    localparam t_cond COND_FINISH   = 3'd4;  // tile blocked or last step checked
    localparam t_cond COND_OUT_FREE = 3'd5;  // result register can take a value

    typedef struct packed {
        logic  in_ready;
        logic  do_norm;
        logic  do_read;
        logic  do_check;
        logic  do_emit;
        t_cond cond;
        t_pc   tgt_true;
        t_pc   tgt_false;
    } t_uword;

    // Control store: one word per step
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{in_ready: 1'b0, do_norm: 1'b0, do_read: 1'b0, do_check: 1'b0,
              do_emit: 1'b0, cond: COND_ALWAYS, tgt_true: PC_IDLE, tgt_false: PC_IDLE};
        case (pc)
            PC_IDLE: begin
                w.in_ready  = 1'b1;
                w.cond      = COND_QUERY_IN;
                w.tgt_true  = PC_NORM;
                w.tgt_false = PC_IDLE;
            end
            PC_NORM: begin
                w.do_norm   = 1'b1;
                w.cond      = COND_NORM_END;
                w.tgt_true  = PC_START;
                w.tgt_false = PC_NORM;
            end
            PC_START: begin
                w.cond      = COND_FAIL;
                w.tgt_true  = PC_EMIT;
                w.tgt_false = PC_READ;
            end
            PC_READ: begin
                w.do_read   = 1'b1;
                w.cond      = COND_ALWAYS;
                w.tgt_true  = PC_CHECK;
                w.tgt_false = PC_CHECK;
            end
            PC_CHECK: begin
                w.do_check  = 1'b1;
                w.cond      = COND_FINISH;
                w.tgt_true  = PC_EMIT;
                w.tgt_false = PC_READ;
            end
            PC_EMIT: begin
                w.do_emit   = 1'b1;
                w.cond      = COND_OUT_FREE;
                w.tgt_true  = PC_IDLE;
                w.tgt_false = PC_EMIT;
            end
            default: begin
                w.cond      = COND_ALWAYS;
                w.tgt_true  = PC_IDLE;
                w.tgt_false = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/tile_line_of_sight_top.sv =====
// Tile flag map with a microcoded line-of-sight walker.
//
//  channel   | direction | handshake                      | payload
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | tuser command, tdata tile/query fields
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata blocked
//  apb       | in        | psel, penable, pwrite, pready  | solid_mask, transparent_mask
//
// A load is written into the map when it is accepted. A query is accepted, then normalized
// by halving (five halvings for a 31-tile delta, then the exit test), then passes one branch
// step; each checked tile takes a map read, then a check, for up to count+1 = 33 tiles, and
// the result is then handed to the output register. The tiles are read one at a time through
// the single map read port walked by the sequencer.
// Reset is synchronous, active low, and clears the sequencer, masks and output valid.
// The map is not cleared. A result waiting on m_axis does not stop loads being taken.
module tile_line_of_sight_top #(
    parameter int MAP_WIDTH  = tlos_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = tlos_pkg::MAP_HEIGHT_DEF,
    parameter int LINE_LIMIT = tlos_pkg::LINE_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [4:0] tile_x, [9:5] tile_y, [17:10] tile_flags, [22:18] from_x,
    // [27:23] from_y, [32:28] to_x, [37:33] to_y, [39:38] zero
    input  logic [tlos_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] command
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] blocked, [7:1] zero
    output logic [tlos_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlos_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tlos_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tlos_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import tlos_pkg::*;

    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(LINE_LIMIT) + 1;
    localparam int TW    = POS_W - FRAC_BITS;   // tile index taken from a position
    localparam int XW    = 16;                  // address product width

    // Map memory
    logic [FLAGS_W-1:0] r_map [DEPTH];
    logic [FLAGS_W-1:0] r_rdata;
    logic               r_inmap;

    // Config registers
    logic [FLAGS_W-1:0] r_solid, r_transp;

    // Sequencer and datapath registers
    t_pc                r_pc, n_pc;
    logic [MAG_W-1:0]   r_mx, r_my;
    logic               r_negx, r_negy;
    logic [CW-1:0]      r_count, r_i;
    logic               r_fail;
    logic               r_result;
    logic signed [POS_W-1:0] r_px, r_py;
    logic               r_out_valid, r_out_blocked;

    t_uword             uw;
    logic               cond_true;

    // Input fields
    logic [COORD_W-1:0] tile_x, tile_y, from_x, from_y, to_x, to_y;
    logic [FLAGS_W-1:0] tile_flags;
    logic               in_accept, load_in, query_in;

    assign tile_x     = s_axis_tdata[4:0];
    assign tile_y     = s_axis_tdata[9:5];
    assign tile_flags = s_axis_tdata[17:10];
    assign from_x     = s_axis_tdata[22:18];
    assign from_y     = s_axis_tdata[27:23];
    assign to_x       = s_axis_tdata[32:28];
    assign to_y       = s_axis_tdata[37:33];

    assign uw            = ucode(r_pc);
    assign s_axis_tready = uw.in_ready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign load_in       = in_accept && (s_axis_tuser == CMD_LOAD);
    assign query_in      = in_accept && (s_axis_tuser == CMD_QUERY);

    // Deltas of the incoming query
    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W:0]        ax, ay;
    assign dx = $signed({1'b0, to_x}) - $signed({1'b0, from_x});
    assign dy = $signed({1'b0, to_y}) - $signed({1'b0, from_y});
    assign ax = dx[COORD_W] ? -dx : dx;
    assign ay = dy[COORD_W] ? -dy : dy;

    // Normalize step
    logic          int_nz;
    logic [CW-1:0] count_dbl;
    logic          limit_hit;
    assign int_nz    = (r_mx[MAG_W-1:FRAC_BITS] != '0) || (r_my[MAG_W-1:FRAC_BITS] != '0);
    assign count_dbl = {r_count[CW-2:0], 1'b0};
    assign limit_hit = int_nz && (count_dbl >= CW'(LINE_LIMIT));

    // Step vector with signs restored
    logic signed [POS_W-1:0] sx, sy;
    assign sx = r_negx ? -$signed(POS_W'(r_mx)) : $signed(POS_W'(r_mx));
    assign sy = r_negy ? -$signed(POS_W'(r_my)) : $signed(POS_W'(r_my));

    // Tile under the current position
    logic [TW-1:0] pos_tx, pos_ty;
    logic          pos_inmap;
    logic [XW-1:0] rd_addr_full, wr_addr_full;
    logic          load_inmap;
    assign pos_tx       = r_px[POS_W-1:FRAC_BITS];
    assign pos_ty       = r_py[POS_W-1:FRAC_BITS];
    assign pos_inmap    = !r_px[POS_W-1] && !r_py[POS_W-1]
                          && (32'(pos_tx) < MAP_WIDTH) && (32'(pos_ty) < MAP_HEIGHT);
    assign rd_addr_full = XW'(pos_ty) * XW'(MAP_WIDTH) + XW'(pos_tx);
    assign wr_addr_full = XW'(tile_y) * XW'(MAP_WIDTH) + XW'(tile_x);
    assign load_inmap   = (32'(tile_x) < MAP_WIDTH) && (32'(tile_y) < MAP_HEIGHT);

    // Check step
    logic blocking, finish;
    assign blocking = r_inmap && ((r_rdata & r_solid) != '0) && ((r_rdata & r_transp) == '0);
    assign finish   = blocking || (r_i == r_count);

    logic out_free;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        case (uw.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_QUERY_IN: cond_true = query_in;
            COND_NORM_END: cond_true = !int_nz || limit_hit;
            COND_FAIL:     cond_true = r_fail;
            COND_FINISH:   cond_true = finish;
            COND_OUT_FREE: cond_true = out_free;
            default:       cond_true = 1'b1;
        endcase
        n_pc = cond_true ? uw.tgt_true : uw.tgt_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Map write port
    always_ff @(posedge i_clk) begin
        if (load_in && load_inmap) begin
            r_map[wr_addr_full[AW-1:0]] <= tile_flags;
        end
    end

    // Map read port
    always_ff @(posedge i_clk) begin
        if (uw.do_read) begin
            r_inmap <= pos_inmap;
            if (pos_inmap) begin
                r_rdata <= r_map[rd_addr_full[AW-1:0]];
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (query_in) begin
            r_mx     <= {ax[COORD_W-1:0], {FRAC_BITS{1'b0}}};
            r_my     <= {ay[COORD_W-1:0], {FRAC_BITS{1'b0}}};
            r_negx   <= dx[COORD_W];
            r_negy   <= dy[COORD_W];
            r_count  <= CW'(1);
            r_i      <= '0;
            r_px     <= $signed(POS_W'({from_x, {FRAC_BITS{1'b0}}}));
            r_py     <= $signed(POS_W'({from_y, {FRAC_BITS{1'b0}}}));
        end
        if (uw.do_norm && int_nz) begin
            r_mx    <= r_mx >> 1;
            r_my    <= r_my >> 1;
            r_count <= count_dbl;
        end
        if (uw.do_check && !finish) begin
            r_px <= r_px + sx;
            r_py <= r_py + sy;
            r_i  <= r_i + CW'(1);
        end
    end

    // Outcome of the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail   <= 1'b0;
            r_result <= 1'b0;
        end else begin
            if (query_in) begin
                r_fail <= 1'b0;
            end else if (uw.do_norm && limit_hit) begin
                r_fail   <= 1'b1;
                r_result <= 1'b1;
            end else if (uw.do_check) begin
                r_result <= blocking;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_out_blocked <= 1'b0;
        end else begin
            if (uw.do_emit && out_free) begin
                r_out_valid   <= 1'b1;
                r_out_blocked <= r_result;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, r_out_blocked};

    // Configuration port
    logic apb_wr;
    logic reg_idx;
    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solid  <= SOLID_RESET;
            r_transp <= TRANSPARENT_RESET;
        end else if (apb_wr) begin
            case (reg_idx)
                REG_SOLID:       r_solid  <= pwdata[FLAGS_W-1:0];
                REG_TRANSPARENT: r_transp <= pwdata[FLAGS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SOLID:       prdata = APB_DATA_W'(r_solid);
            REG_TRANSPARENT: prdata = APB_DATA_W'(r_transp);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== tb/tlos_checker.sv =====
// Checker for the tile line-of-sight block: mirrors map and masks, predicts and compares results.
module tlos_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    // [4:0] tile_x, [9:5] tile_y, [17:10] tile_flags, [22:18] from_x,
    // [27:23] from_y, [32:28] to_x, [37:33] to_y, [39:38] zero
    input  logic [tlos_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [0] command
    input  logic                              i_s_tuser,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // [0] blocked, [7:1] zero
    input  logic [tlos_pkg::OUT_DATA_W-1:0]   i_m_tdata,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic                              i_pready,
    input  logic [tlos_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  logic [tlos_pkg::APB_DATA_W-1:0]   i_pwdata,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tlos_pkg::*;

    localparam int INT_PART = 'hFF00;

    typedef struct packed {
        logic [1:0]         pad;
        logic [COORD_W-1:0] to_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] from_x;
        logic [FLAGS_W-1:0] tile_flags;
        logic [COORD_W-1:0] tile_y;
        logic [COORD_W-1:0] tile_x;
    } t_item;

    logic [FLAGS_W-1:0] tile_map [MAP_WIDTH_DEF*MAP_HEIGHT_DEF];
    logic [FLAGS_W-1:0] solid_mask_now       = SOLID_RESET;
    logic [FLAGS_W-1:0] transparent_mask_now = TRANSPARENT_RESET;
    logic               blocked_expected [$];
    int                 fails = 0;

    // Tiles outside the map, negative positions included, read as open.
    function automatic bit tile_blocks(input int px, input int py);
        logic [FLAGS_W-1:0] f;
        if (px < 0 || py < 0)
            return 1'b0;
        if ((px >>> FRAC_BITS) >= MAP_WIDTH_DEF || (py >>> FRAC_BITS) >= MAP_HEIGHT_DEF)
            return 1'b0;
        f = tile_map[(py >>> FRAC_BITS) * MAP_WIDTH_DEF + (px >>> FRAC_BITS)];
        return (f & solid_mask_now) != 0 && (f & transparent_mask_now) == 0;
    endfunction

    function automatic logic line_is_blocked(input int fx, input int fy,
                                             input int tx, input int ty);
        int dx, dy, mx, my, steps, px, py, sx, sy;
        dx = tx - fx;
        dy = ty - fy;
        mx = (dx < 0 ? -dx : dx) << FRAC_BITS;
        my = (dy < 0 ? -dy : dy) << FRAC_BITS;
        steps = 1;
        // halve until both deltas are below one tile, give up on long lines
        while (((mx | my) & INT_PART) != 0) begin
            mx = mx >> 1;
            my = my >> 1;
            steps = steps << 1;
            if (steps >= LINE_LIMIT_DEF)
                return 1'b1;
        end
        px = fx << FRAC_BITS;
        py = fy << FRAC_BITS;
        if (tile_blocks(px, py))
            return 1'b1;
        sx = (dx < 0) ? -mx : mx;
        sy = (dy < 0) ? -my : my;
        for (int i = 0; i < steps; i++) begin
            px += sx;
            py += sy;
            if (tile_blocks(px, py))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : track
        t_item item;
        logic  want;
        if (!i_rst_n) begin
            solid_mask_now       = SOLID_RESET;
            transparent_mask_now = TRANSPARENT_RESET;
            blocked_expected.delete();
        end else begin
            // retire results before taking new items: a result never belongs to a same-edge query
            if (i_m_tvalid && i_m_tready) begin
                if (blocked_expected.size() == 0) begin
                    fails++;
                    $display("%0t: result with no query waiting, expected none got blocked=%0b",
                             $time, i_m_tdata[0]);
                end else begin
                    want = blocked_expected.pop_front();
                    if (i_m_tdata[0] !== want) begin
                        fails++;
                        $display("%0t: blocked mismatch, expected %0b got %0b",
                                 $time, want, i_m_tdata[0]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                item = t_item'(i_s_tdata);
                if (i_s_tuser == CMD_LOAD)
                    tile_map[item.tile_y * MAP_WIDTH_DEF + item.tile_x] = item.tile_flags;
                else
                    blocked_expected.push_back(line_is_blocked(item.from_x, item.from_y,
                                                               item.to_x, item.to_y));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[APB_ADDR_W-1:2] == REG_SOLID)
                    solid_mask_now = i_pwdata[FLAGS_W-1:0];
                else if (i_paddr[APB_ADDR_W-1:2] == REG_TRANSPARENT)
                    transparent_mask_now = i_pwdata[FLAGS_W-1:0];
            end
        end
        o_pending    <= blocked_expected.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the tile line-of-sight testbench: clock, reset, stimulus, idling and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tlos_pkg::*;

    localparam int PHASES          = 6;
    localparam int PHASE_ITEMS     = 88;
    localparam int IDLE_PCT        = 76;
    localparam int BOTH_PCT        = 18;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int NEAR_SPAN       = 3;
    localparam int MISSING_MAX     = 24;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = CMD_LOAD;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int results_pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off_armed = 1'b0;
    int quiet_cycles   = 0;

    int items_sent   = 0;
    int loads_sent   = 0;
    int queries_sent = 0;
    bit tile_written [32][32];
    logic [FLAGS_W-1:0] solid_now       = SOLID_RESET;
    logic [FLAGS_W-1:0] transparent_now = TRANSPARENT_RESET;

    always #5 i_clk = ~i_clk;

    tile_line_of_sight_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tlos_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    // Result side: random stalls, plus one long hold-off when armed.
    initial begin : result_sink
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_armed && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int clip_coord(input int v);
        return (v < 0) ? 0 : (v > 31) ? 31 : v;
    endfunction

    // Mostly open tiles so that lines are not all blocked.
    function automatic logic [FLAGS_W-1:0] pick_flags();
        logic [FLAGS_W-1:0] f;
        f = FLAGS_W'($urandom);
        case ($urandom_range(3))
            0, 1: f &= ~solid_now;
            2:    f |= transparent_now;
            default: ;
        endcase
        return f;
    endfunction

    task automatic send_item(input logic cmd, input logic [IN_DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_load(input int x, input int y, input logic [FLAGS_W-1:0] flags);
        send_item(CMD_LOAD, {2'b00, 20'($urandom), flags, 5'(y), 5'(x)});
        tile_written[y][x] = 1'b1;
        loads_sent++;
    endtask

    task automatic send_query(input int fx, input int fy, input int tx, input int ty);
        send_item(CMD_QUERY, {2'b00, 5'(ty), 5'(tx), 5'(fy), 5'(fx), 18'($urandom)});
        queries_sent++;
    endtask

    // The walk stays inside the bounding box, so load every unwritten tile in it first.
    task automatic ask_query(input int fx, input int fy, input int tx, input int ty);
        for (int y = (fy < ty ? fy : ty); y <= (fy < ty ? ty : fy); y++)
            for (int x = (fx < tx ? fx : tx); x <= (fx < tx ? tx : fx); x++)
                if (!tile_written[y][x])
                    send_load(x, y, pick_flags());
        send_query(fx, fy, tx, ty);
    endtask

    task automatic run_sequence();
        int kind, fx, fy, tx, ty, missing;
        kind = $urandom_range(99);
        fx = $urandom_range(31);
        fy = $urandom_range(31);
        if (kind < 15) begin
            send_load(fx, fy, pick_flags());
            return;
        end
        tx = clip_coord(fx + $urandom_range(2 * NEAR_SPAN) - NEAR_SPAN);
        ty = clip_coord(fy + $urandom_range(2 * NEAR_SPAN) - NEAR_SPAN);
        if (kind >= 70 && kind < 88) begin
            // long row or column line, one tile of drift at most
            if ($urandom_range(1)) begin
                fx = $urandom_range(1) ? 0 : $urandom_range(31);
                tx = $urandom_range(1) ? 31 : $urandom_range(31);
                ty = clip_coord(fy + $urandom_range(2) - 1);
            end else begin
                fy = $urandom_range(1) ? 31 : $urandom_range(31);
                ty = $urandom_range(1) ? 0 : $urandom_range(31);
                tx = clip_coord(fx + $urandom_range(2) - 1);
            end
        end else if (kind >= 88) begin
            missing = 0;
            for (int y = 0; y < 32; y++)
                for (int x = 0; x < 32; x++)
                    if (!tile_written[y][x] && y >= (fy < ty ? fy : ty) &&
                        x >= (fx < tx ? fx : tx))
                        missing++;
            // keep any endpoints only when the map around them is mostly loaded
            if (missing <= MISSING_MAX) begin
                tx = $urandom_range(31);
                ty = $urandom_range(31);
                missing = 0;
                for (int y = (fy < ty ? fy : ty); y <= (fy < ty ? ty : fy); y++)
                    for (int x = (fx < tx ? fx : tx); x <= (fx < tx ? tx : fx); x++)
                        if (!tile_written[y][x])
                            missing++;
                if (missing > MISSING_MAX)
                    ty = fy;
            end
            if (ty == fy)
                tx = clip_coord(fx + $urandom_range(2 * NEAR_SPAN) - NEAR_SPAN);
        end
        ask_query(fx, fy, tx, ty);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        // loads give no result; let the last one settle
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [FLAGS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_W-FLAGS_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SOLID)
            solid_now = value;
        else
            transparent_now = value;
    endtask

    initial begin : stimulus
        int phase_end, phase_mid;
        bit paused;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners, adjacent tiles, both directions, transparent and solid starts
        send_load(0, 0, 8'h00);
        send_load(31, 31, 8'hFF);
        send_load(31, 0, 8'h01);
        send_load(0, 31, 8'h03);
        send_query(0, 0, 0, 0);
        send_query(31, 31, 31, 31);
        send_query(31, 0, 31, 0);
        send_query(0, 31, 0, 31);
        send_load(1, 0, 8'h00);
        send_load(31, 30, 8'h00);
        send_load(1, 1, 8'h02);
        send_load(0, 1, 8'h01);
        send_query(0, 0, 1, 0);
        send_query(1, 0, 0, 0);
        send_query(31, 30, 31, 31);
        send_query(31, 31, 31, 30);
        send_query(0, 0, 1, 1);
        send_query(1, 0, 0, 1);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                1: begin
                    write_reg(REG_SOLID, 8'hFF);
                    write_reg(REG_TRANSPARENT, 8'h00);
                end
                2: begin
                    write_reg(REG_SOLID, 8'h00);
                    write_reg(REG_TRANSPARENT, 8'hFF);
                end
                3: begin
                    write_reg(REG_SOLID, FLAGS_W'($urandom));
                    write_reg(REG_TRANSPARENT, FLAGS_W'($urandom));
                end
                4: begin
                    write_reg(REG_SOLID, 8'h81);
                    write_reg(REG_TRANSPARENT, 8'h02);
                end
                5: begin
                    write_reg(REG_SOLID, SOLID_RESET);
                    write_reg(REG_TRANSPARENT, TRANSPARENT_RESET);
                end
                default: ;
            endcase
            case (ph)
                1: begin
                    send_idle_pct  <= IDLE_PCT;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= IDLE_PCT;
                end
                3, 5: begin
                    send_idle_pct  <= BOTH_PCT;
                    recv_stall_pct <= BOTH_PCT;
                end
                default: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                end
            endcase
            if (ph == 4)
                hold_off_armed <= 1'b1;
            @(posedge i_clk);
            phase_end = items_sent + PHASE_ITEMS;
            phase_mid = items_sent + PHASE_ITEMS / 2;
            paused = 1'b0;
            while (items_sent < phase_end) begin
                run_sequence();
                if (ph == 4 && !paused && items_sent >= phase_mid) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end
        drain_results();

        $display("Covered %0d tile loads and %0d line queries under six mask settings,",
                 loads_sent, queries_sent);
        $display("with sender gaps, result stalls, a long result hold-off and drained pauses.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tlos_pkg.sv
rtl/tile_line_of_sight_top.sv
tb/tlos_checker.sv
tb/testbench.sv
